[design/sorted_array_linked_list_assert.svh]
// Assertion macros used by the sorted list checker.
`ifndef SORTED_ARRAY_LINKED_LIST_ASSERT_SVH
`define SORTED_ARRAY_LINKED_LIST_ASSERT_SVH

// same-cycle implication
`define SAL_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SAL_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/sal_pkg.sv]
// Types and constants of the sorted linked list block.
`timescale 1ns / 1ps
`default_nettype none
package sal_pkg;

   localparam int OP_BITS        = 2;
   localparam int KEY_IN_BITS    = 32;
   localparam int KEY_MAX_BITS   = 64;
   localparam int STATUS_BITS    = 2;
   localparam int SLOT_OUT_BITS  = 6;
   localparam int COUNT_OUT_BITS = 7;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef logic [SLOT_OUT_BITS-1:0]  slot_out_type;
   typedef logic [COUNT_OUT_BITS-1:0] count_out_type;

endpackage
`default_nettype wire

[design/sal_req_if.sv]
// Request channel: op and key.
`timescale 1ns / 1ps
`default_nettype none
interface sal_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [sal_pkg::OP_BITS-1:0]     op;
   logic signed [sal_pkg::KEY_IN_BITS-1:0] key;

   modport source (output valid, output op, output key, input ready);
   modport sink   (input valid, input op, input key, output ready);
endinterface
`default_nettype wire

[design/sal_rsp_if.sv]
// Response channel: status, slot and element count.
`timescale 1ns / 1ps
`default_nettype none
interface sal_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [sal_pkg::STATUS_BITS-1:0]       status;
   logic [sal_pkg::SLOT_OUT_BITS-1:0]     slot;
   logic [sal_pkg::COUNT_OUT_BITS-1:0]    count;

   modport source (output valid, output status, output slot, output count, input ready);
   modport sink   (input valid, input status, input slot, input count, output ready);
endinterface
`default_nettype wire

[design/sorted_array_linked_list.sv]
// Path from accept to response: insert S_ALLOC, S_WALK (n nodes passed, up to DEPTH), S_FIX,
// S_DONE; present delete S_WALK, S_FIX, S_DONE; search or failed delete S_WALK, S_DONE;
// clear and full insert S_DONE. Throughput: one item at a time, the next accepted once
// the response loads, which waits while the sink holds the last one; the walk reads one
// node per cycle. Reset: synchronous; free slots at or above the fill mark link
// implicitly, so neither reset nor clear sweeps the memories.
`timescale 1ns / 1ps
`default_nettype none
module sorted_array_linked_list #(
   parameter int DEPTH    = 64,
   parameter int KEY_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   sal_req_if.sink   req_ch,
   sal_rsp_if.source rsp_ch
);

   localparam int SW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);
   localparam logic [LW-1:0] NIL  = LW'(DEPTH);
   localparam logic [LW-1:0] LAST = LW'(DEPTH - 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ALLOC = 5'b00010,
      S_WALK  = 5'b00100,
      S_FIX   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   logic [KEY_BITS-1:0] key_mem  [DEPTH];
   logic [LW-1:0]       link_mem [DEPTH];

   state_type           state_ff, state_in;
   sal_pkg::op_type     op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [LW-1:0]       cur_ff, cur_in;
   logic [LW-1:0]       prev_ff, prev_in;
   logic [LW-1:0]       slot_ff, slot_in;
   logic [LW-1:0]       list_head_ff, list_head_in;
   logic [LW-1:0]       free_head_ff, free_head_in;
   logic [LW-1:0]       fill_ff, fill_in;
   logic [LW-1:0]       count_ff, count_in;
   logic [SW-1:0]       fix_addr_ff, fix_addr_in;
   logic [LW-1:0]       fix_data_ff, fix_data_in;
   logic                fix_head_ff, fix_head_in;
   sal_pkg::status_type res_status_ff, res_status_in;
   logic [LW-1:0]       res_slot_ff, res_slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sal_pkg::status_type rsp_status_ff, rsp_status_in;
   sal_pkg::slot_out_type  rsp_slot_ff, rsp_slot_in;
   sal_pkg::count_out_type rsp_count_ff, rsp_count_in;

   logic [KEY_BITS-1:0] key_q_ff;
   logic [LW-1:0]       link_q_ff;

   logic                rd_en;
   logic [LW-1:0]       rd_addr;
   logic                key_we;
   logic [SW-1:0]       key_wa;
   logic                link_we;
   logic [SW-1:0]       link_wa;
   logic [LW-1:0]       link_wd;

   logic [sal_pkg::KEY_MAX_BITS-1:0] key_wide;
   logic [KEY_BITS-1:0] key_biased;
   logic                key_less;
   logic                key_match;

   // sign bit flipped so unsigned order equals signed order
   assign key_wide = {{(sal_pkg::KEY_MAX_BITS - sal_pkg::KEY_IN_BITS)
                       {req_ch.key[sal_pkg::KEY_IN_BITS-1]}}, req_ch.key};
   assign key_biased = key_wide[KEY_BITS-1:0] ^ {1'b1, {(KEY_BITS - 1){1'b0}}};
   assign key_less   = (cur_ff != NIL) && (key_q_ff < key_ff);
   assign key_match  = (cur_ff != NIL) && (key_q_ff == key_ff);

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.slot   = rsp_slot_ff;
   assign rsp_ch.count  = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      slot_in       = slot_ff;
      list_head_in  = list_head_ff;
      free_head_in  = free_head_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      fix_addr_in   = fix_addr_ff;
      fix_data_in   = fix_data_ff;
      fix_head_in   = fix_head_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = cur_ff;
      key_we        = 1'b0;
      key_wa        = slot_ff[SW-1:0];
      link_we       = 1'b0;
      link_wa       = slot_ff[SW-1:0];
      link_wd       = cur_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in         = sal_pkg::op_type'(req_ch.op);
               key_in        = key_biased;
               prev_in       = NIL;
               cur_in        = list_head_ff;
               res_status_in = sal_pkg::ST_DONE;
               res_slot_in   = '0;
               case (sal_pkg::op_type'(req_ch.op))
                  sal_pkg::OP_INSERT: begin
                     if (free_head_ff == NIL) begin
                        res_status_in = sal_pkg::ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        slot_in  = free_head_ff;
                        rd_addr  = free_head_ff;
                        rd_en    = 1'b1;
                        state_in = S_ALLOC;
                     end
                  end
                  sal_pkg::OP_DELETE, sal_pkg::OP_SEARCH: begin
                     rd_addr  = list_head_ff;
                     rd_en    = (list_head_ff != NIL);
                     state_in = S_WALK;
                  end
                  default: begin
                     list_head_in = NIL;
                     free_head_in = '0;
                     fill_in      = '0;
                     count_in     = '0;
                     state_in     = S_DONE;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            // slots at or above the fill mark were never taken: next is slot + 1
            if (slot_ff < fill_ff) begin
               free_head_in = link_q_ff;
            end else begin
               fill_in      = fill_ff + LW'(1);
               free_head_in = (slot_ff == LAST) ? NIL : slot_ff + LW'(1);
            end
            key_we   = 1'b1;
            rd_addr  = cur_ff;
            rd_en    = (cur_ff != NIL);
            state_in = S_WALK;
         end
         S_WALK: begin
            if (key_less) begin
               prev_in = cur_ff;
               cur_in  = link_q_ff;
               rd_addr = link_q_ff;
               rd_en   = (link_q_ff != NIL);
            end else begin
               fix_head_in = (prev_ff == NIL);
               fix_addr_in = prev_ff[SW-1:0];
               case (op_ff)
                  sal_pkg::OP_INSERT: begin
                     link_we     = 1'b1;
                     fix_data_in = slot_ff;
                     res_slot_in = slot_ff;
                     state_in    = S_FIX;
                  end
                  sal_pkg::OP_DELETE: begin
                     if (key_match) begin
                        link_we      = 1'b1;
                        link_wa      = cur_ff[SW-1:0];
                        link_wd      = free_head_ff;
                        free_head_in = cur_ff;
                        fix_data_in  = link_q_ff;
                        res_slot_in  = cur_ff;
                        state_in     = S_FIX;
                     end else begin
                        res_status_in = sal_pkg::ST_NOT_FOUND;
                        state_in      = S_DONE;
                     end
                  end
                  sal_pkg::OP_SEARCH: begin
                     if (key_match) begin
                        res_slot_in = cur_ff;
                     end else begin
                        res_status_in = sal_pkg::ST_NOT_FOUND;
                     end
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_FIX: begin
            if (fix_head_ff) begin
               list_head_in = fix_data_ff;
            end else begin
               link_we = 1'b1;
               link_wa = fix_addr_ff;
               link_wd = fix_data_ff;
            end
            if (op_ff == sal_pkg::OP_INSERT) begin
               count_in = count_ff + LW'(1);
            end else if (count_ff != '0) begin
               count_in = count_ff - LW'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = sal_pkg::slot_out_type'(res_slot_ff);
               rsp_count_in  = sal_pkg::count_out_type'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_wa] <= key_ff;
      end
      if (rd_en) begin
         key_q_ff <= key_mem[rd_addr[SW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (rd_en) begin
         link_q_ff <= link_mem[rd_addr[SW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         list_head_ff <= NIL;
         free_head_ff <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      slot_ff       <= slot_in;
      fix_addr_ff   <= fix_addr_in;
      fix_data_ff   <= fix_data_in;
      fix_head_ff   <= fix_head_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule
`default_nettype wire

[design/sal_checker.sv]
// Port-level checks for the sorted linked list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_array_linked_list_assert.svh"
module sal_checker #(
   parameter int DEPTH = 64
) (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic [sal_pkg::STATUS_BITS-1:0]      rsp_status,
   input wire logic [sal_pkg::SLOT_OUT_BITS-1:0]    rsp_slot,
   input wire logic [sal_pkg::COUNT_OUT_BITS-1:0]   rsp_count
);

   localparam logic [sal_pkg::COUNT_OUT_BITS-1:0] FULL_COUNT =
      sal_pkg::count_out_type'(DEPTH);

   `SAL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   `SAL_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_count), "rsp item changed while stalled")
   `SAL_ASSERT_IMP(a_fail_slot, clock, reset, rsp_valid && (rsp_status != sal_pkg::ST_DONE), rsp_slot == '0, "nonzero slot on failed item")
   `SAL_ASSERT_IMP(a_full_count, clock, reset, rsp_valid && (rsp_status == sal_pkg::ST_FULL), rsp_count == FULL_COUNT, "full reported below capacity")

endmodule

bind sorted_array_linked_list sal_checker #(
   .DEPTH (DEPTH)
) u_sal_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_slot   (rsp_ch.slot),
   .rsp_count  (rsp_ch.count)
);
`default_nettype wire
